### hdl/mlss_pkg.sv
package mlss_pkg;

  localparam int MAX_DIM = 128;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ELEM_W = 16;
  localparam int SUM_W  = ELEM_W + IDX_W + 1;
  localparam int DIM_W  = 8;
  localparam int OUT_W  = 22;
  localparam int OUT_MAX = (1 << OUT_W) - 1;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 24;

  localparam int DIMC_W = (DIM_W > IDX_W + 1) ? DIM_W : IDX_W + 1;
  localparam int CMP_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W + 1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(100);

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

### hdl/max_line_sum_square_matrix.sv
// Streams the elements of a square matrix, row-major, one per transaction on the slave
// side, and returns one transaction on the master side after the last element of each
// matrix: the largest row, column, main-diagonal or anti-diagonal sum, floored at zero.
// The matrix size comes from cfg_wdata_i (0 reads as 1, values above 128 as 128); a write
// restarts the matrix and must only happen while no element is in flight. One element is
// taken per cycle: the column sums sit in a 128-entry memory with a registered read, and
// each element's sum is read as it enters stage 1, added there and written back as it
// leaves, with forwarding. The result then moves through stage 2 to the output register;
// while a result waits on the master side, s_axis_tready_o is low and the pipeline holds.
// Column-sum entries carry valid bits, so a new matrix starts at once with no clearing pass.
module max_line_sum_square_matrix (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mlss_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mlss_pkg::TDATA_IN_W-1:0]     s_axis_tdata_i,   // [15:0] element
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [mlss_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_o    // [21:0] max_line_sum
);

  localparam int IW = mlss_pkg::IDX_W;
  localparam int SW = mlss_pkg::SUM_W;
  localparam int CW = mlss_pkg::CMP_W;
  localparam int NW = mlss_pkg::DIMC_W;

  // configuration and position
  logic [mlss_pkg::DIM_W-1:0] dim_q;
  logic [NW-1:0]              dim_ext;
  logic [NW-1:0]              n_act;
  mlss_pkg::idx_t             last;
  mlss_pkg::idx_t             row_q, row_d, col_q, col_d;
  logic [IW:0]                rc_sum;

  logic adv, accept;

  // column sum store
  mlss_pkg::sum_t     col_mem [mlss_pkg::MAX_DIM];
  mlss_pkg::sum_t     rd_q;
  logic [mlss_pkg::MAX_DIM-1:0] colv_q;

  // stage 1
  logic               s1_v_q;
  mlss_pkg::sum_t     s1_e_q;
  mlss_pkg::idx_t     s1_col_q;
  logic               s1_lrow_q, s1_lcol_q, s1_diag_q, s1_anti_q;
  logic               s1_zero_q, s1_fwd_q;
  mlss_pkg::sum_t     s1_fwdv_q;
  logic               s1_end;
  mlss_pkg::sum_t     old_col, col_new, row_new, main_new, anti_new;
  mlss_pkg::sum_t     row_sum_q, main_q, anti_q;

  // stage 2
  logic               s2_v_q, s2_end_q;
  mlss_pkg::sum_t     c_col_q, c_row_q, c_main_q, c_anti_q;
  mlss_pkg::sum_t     best_q, m0, m1, m2, best_new;
  logic [CW-1:0]      best_wide;

  // output register
  logic                           out_v_q;
  logic [mlss_pkg::OUT_W-1:0]     out_q;

  assign dim_ext = NW'(dim_q);

  always_comb begin
    if (dim_ext == '0) begin
      n_act = NW'(1);
    end else if (dim_ext > NW'(mlss_pkg::MAX_DIM)) begin
      n_act = NW'(mlss_pkg::MAX_DIM);
    end else begin
      n_act = dim_ext;
    end
  end

  assign last   = IW'(n_act - NW'(1));
  assign rc_sum = {1'b0, row_q} + {1'b0, col_q};

  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_q >= last) begin
      col_d = '0;
      row_d = (row_q >= last) ? '0 : row_q + IW'(1);
    end else begin
      col_d = col_q + IW'(1);
    end
  end

  // stage 1 arithmetic
  assign s1_end = s1_lrow_q && s1_lcol_q;

  always_comb begin
    if (s1_fwd_q) begin
      old_col = s1_fwdv_q;
    end else if (s1_zero_q) begin
      old_col = '0;
    end else begin
      old_col = rd_q;
    end
  end

  assign col_new  = old_col + s1_e_q;
  assign row_new  = row_sum_q + s1_e_q;
  assign main_new = s1_diag_q ? main_q + s1_e_q : main_q;
  assign anti_new = s1_anti_q ? anti_q + s1_e_q : anti_q;

  // stage 2 max tree
  assign m0       = (c_col_q > c_row_q) ? c_col_q : c_row_q;
  assign m1       = (c_main_q > c_anti_q) ? c_main_q : c_anti_q;
  assign m2       = (m0 > m1) ? m0 : m1;
  assign best_new = (m2 > best_q) ? m2 : best_q;
  assign best_wide = CW'(best_new);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= col_mem[col_q];
    end
    if (adv && s1_v_q) begin
      col_mem[s1_col_q] <= col_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_e_q    <= SW'(signed'(s_axis_tdata_i));
      s1_col_q  <= col_q;
      s1_lrow_q <= row_q >= last;
      s1_lcol_q <= col_q >= last;
      s1_diag_q <= row_q == col_q;
      s1_anti_q <= rc_sum == {1'b0, last};
      s1_zero_q <= (s1_v_q && s1_end) || !colv_q[col_q];
      s1_fwd_q  <= s1_v_q && !s1_end && (s1_col_q == col_q);
      s1_fwdv_q <= col_new;
    end
    if (adv) begin
      c_col_q  <= (s1_v_q && s1_lrow_q) ? col_new : '0;
      c_row_q  <= (s1_v_q && s1_lcol_q) ? row_new : '0;
      c_main_q <= (s1_v_q && s1_end) ? main_new : '0;
      c_anti_q <= (s1_v_q && s1_end) ? anti_new : '0;
      if (s2_v_q && s2_end_q) begin
        out_q <= (best_wide > CW'(mlss_pkg::OUT_MAX)) ? mlss_pkg::OUT_W'(mlss_pkg::OUT_MAX)
                                                      : best_wide[mlss_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q     <= mlss_pkg::DIM_RESET;
      row_q     <= '0;
      col_q     <= '0;
      colv_q    <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s2_end_q  <= 1'b0;
      row_sum_q <= '0;
      main_q    <= '0;
      anti_q    <= '0;
      best_q    <= '0;
      out_v_q   <= 1'b0;
    end else if (cfg_we_i) begin
      dim_q     <= cfg_wdata_i;
      row_q     <= '0;
      col_q     <= '0;
      colv_q    <= '0;
      row_sum_q <= '0;
      main_q    <= '0;
      anti_q    <= '0;
      best_q    <= '0;
    end else begin
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (adv) begin
        s1_v_q   <= accept;
        s2_v_q   <= s1_v_q;
        s2_end_q <= s1_v_q && s1_end;
        if (s1_v_q) begin
          row_sum_q <= s1_lcol_q ? '0 : row_new;
          main_q    <= s1_end ? '0 : main_new;
          anti_q    <= s1_end ? '0 : anti_new;
          if (s1_end) begin
            colv_q <= '0;
          end else begin
            colv_q[s1_col_q] <= 1'b1;
          end
        end
        if (s2_v_q) begin
          best_q <= s2_end_q ? '0 : best_new;
        end
        out_v_q <= s2_v_q && s2_end_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = mlss_pkg::TDATA_OUT_W'(out_q);

endmodule

### tb/max_line_sum_square_matrix_tb.sv
`timescale 1ns / 100ps

module max_line_sum_square_matrix_tb;

  localparam int STALL_LIMIT = 4000;

  typedef enum int {MIX_ANY, MIX_EXTREME, MIX_TINY, MIX_POSITIVE, MIX_NEGATIVE} mix_e;

  class max_line_sum_board;
    logic [mlss_pkg::DIM_W-1:0] dim_code;
    mlss_pkg::sum_t col_acc [mlss_pkg::MAX_DIM];
    mlss_pkg::sum_t row_acc;
    mlss_pkg::sum_t main_acc;
    mlss_pkg::sum_t anti_acc;
    mlss_pkg::sum_t best;
    mlss_pkg::idx_t row_pos;
    mlss_pkg::idx_t col_pos;
    logic [mlss_pkg::OUT_W-1:0] pending [$];
    int mismatches;

    function new();
      dim_code = mlss_pkg::DIM_RESET;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      foreach (col_acc[i]) col_acc[i] = '0;
      row_acc = '0;
      main_acc = '0;
      anti_acc = '0;
      best = '0;
      row_pos = '0;
      col_pos = '0;
    endfunction

    function void set_dimension(logic [mlss_pkg::DIM_W-1:0] code);
      dim_code = code;
      clear();
    endfunction

    function void keep(mlss_pkg::sum_t v);
      if (v > best) best = v;
    endfunction

    function void accept_element(logic signed [mlss_pkg::ELEM_W-1:0] e);
      int n;
      int last;
      logic [mlss_pkg::OUT_W-1:0] sum_out;
      n = (dim_code == 0) ? 1 : (dim_code > mlss_pkg::MAX_DIM) ? mlss_pkg::MAX_DIM
                                                               : int'(dim_code);
      last = n - 1;
      row_acc = row_acc + e;
      col_acc[col_pos] = col_acc[col_pos] + e;
      if (row_pos == col_pos) main_acc = main_acc + e;
      if (int'(row_pos) + int'(col_pos) == last) anti_acc = anti_acc + e;
      if (int'(row_pos) >= last) keep(col_acc[col_pos]);
      if (int'(col_pos) >= last) begin
        keep(row_acc);
        row_acc = '0;
        col_pos = '0;
        if (int'(row_pos) >= last) begin
          keep(main_acc);
          keep(anti_acc);
          sum_out = (best > mlss_pkg::OUT_MAX) ? mlss_pkg::OUT_W'(mlss_pkg::OUT_MAX)
                                               : best[mlss_pkg::OUT_W-1:0];
          pending.push_back(sum_out);
          clear();
        end else begin
          row_pos = row_pos + 1'b1;
        end
      end else begin
        col_pos = col_pos + 1'b1;
      end
    endfunction

    function void compare_sum(logic [mlss_pkg::OUT_W-1:0] got);
      logic [mlss_pkg::OUT_W-1:0] want;
      if (pending.size() == 0) begin
        $error("max_line_sum expected none got %0d", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("max_line_sum expected %0d got %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [mlss_pkg::DIM_W-1:0]       cfg_wdata_i = '0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [mlss_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [mlss_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o;

  int send_idle_pct = 29;
  int recv_idle_pct = 46;
  int stall_cycles = 0;

  max_line_sum_board board = new();

  max_line_sum_square_matrix dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.compare_sum(m_axis_tdata_o[mlss_pkg::OUT_W-1:0]);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  task automatic push_element(input logic [mlss_pkg::ELEM_W-1:0] value);
    logic hit;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= value;
    do begin
      @(negedge clk_i);
      hit = s_axis_tready_o;
      @(posedge clk_i);
    end while (!hit);
    board.accept_element(value);
  endtask

  // hold the sender until every pending sum has been returned
  task automatic hold_sender();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
  endtask

  task automatic write_dimension(input logic [mlss_pkg::DIM_W-1:0] code);
    hold_sender();
    repeat (6) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    board.set_dimension(code);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [mlss_pkg::ELEM_W-1:0] pick_element(mix_e mix);
    case (mix)
      MIX_ANY: return mlss_pkg::ELEM_W'($urandom);
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      MIX_TINY: return mlss_pkg::ELEM_W'($urandom_range(16) - 8);
      MIX_POSITIVE: return mlss_pkg::ELEM_W'($urandom_range(32767));
      default: return mlss_pkg::ELEM_W'(-$urandom_range(32768, 1));
    endcase
  endfunction

  task automatic run_matrices(input int budget);
    int fed;
    int n;
    int count;
    int reps;
    int roll;
    bit cut;
    logic [mlss_pkg::DIM_W-1:0] code;
    mix_e mix;
    fed = 0;
    while (fed < budget) begin
      roll = $urandom_range(99);
      if (roll < 8) code = '0;
      else if (roll < 16) code = mlss_pkg::DIM_W'(1);
      else if (roll < 85) code = mlss_pkg::DIM_W'($urandom_range(8, 2));
      else code = mlss_pkg::DIM_W'($urandom_range(16, 9));
      write_dimension(code);
      n = (code == 0) ? 1 : int'(code);
      reps = $urandom_range(4, 1);
      cut = 1'b0;
      for (int m = 0; m < reps && !cut; m++) begin
        mix = mix_e'($urandom_range(4));
        count = n * n;
        // now and then abandon the matrix, often part-way, and restart with a new size write
        if ($urandom_range(9) == 0) begin
          count = $urandom_range(n * n, 1);
          cut = 1'b1;
        end
        for (int i = 0; i < count && fed < budget; i++) begin
          if ($urandom_range(149) == 0) hold_sender();
          push_element(pick_element(mix));
          fed++;
        end
      end
    end
  endtask

  // size over 128, two rows plus three; the next size write restarts the matrix
  task automatic run_full_size();
    write_dimension(8'hFF);
    for (int i = 0; i < 2 * mlss_pkg::MAX_DIM + 3; i++) begin
      push_element((i < mlss_pkg::MAX_DIM) ? 16'h7FFF
                                           : pick_element(mix_e'($urandom_range(4))));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_dimension(8'h00);
    push_element(16'h7FFF);
    push_element(16'h8000);

    write_dimension(8'h02);
    repeat (4) push_element(16'h7FFF);
    hold_sender();
    push_element(16'hFFFF);
    push_element(16'hFFFF);
    push_element(16'hFFFF);
    push_element(16'h8000);

    // restart a 3 by 3 matrix part-way through
    write_dimension(8'h03);
    push_element(16'h0001);
    push_element(16'h0002);
    push_element(16'h0003);
    push_element(16'h0004);
    write_dimension(8'h03);
    push_element(16'h0005);
    push_element(16'hFFF9);
    push_element(16'h0064);
    push_element(16'h8000);
    push_element(16'h7FFF);
    push_element(16'h0000);
    push_element(16'h0003);
    push_element(16'h0003);
    push_element(16'h0003);

    send_idle_pct = 29;
    recv_idle_pct = 46;
    run_matrices(523);

    send_idle_pct = 46;
    recv_idle_pct = 29;
    run_matrices(523);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_full_size();
    run_matrices(523);

    hold_sender();
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
